// ----- rtl/spp_pkg.sv -----
// Shared types, constants and the CORDIC arc table of the spherical proximity block.
package spp_pkg;

   localparam int POS_BITS      = 24;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int PHASE_BITS    = 32;
   localparam int TRIG_W        = 34;
   localparam int TRIG_FRAC     = 30;
   localparam int CSR_IDX_BITS  = 4;

   localparam logic [TRIG_W-1:0] CORDIC_START = TRIG_W'(652032874);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TOLERANCE  = 4'd0,
      CSR_ANGLE_UNIT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   position_a;
      logic [ANGLE_BITS-1:0] incl_a;
      logic [ANGLE_BITS-1:0] azim_a;
      logic [POS_BITS-1:0]   position_b;
      logic [ANGLE_BITS-1:0] incl_b;
      logic [ANGLE_BITS-1:0] azim_b;
   } req_type;

   typedef struct packed {
      logic is_close;
      logic a_before_b;
   } rsp_type;

   // Arc tangent of 2^-k in binary angle units, 2^32 to a full turn.
   function automatic logic [PHASE_BITS-1:0] arc_angle(input int k);
      logic [PHASE_BITS-1:0] a;
      case (k)
         0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
         3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
         6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
         9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
         12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2FA;
         15: a = 32'h0000517D;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
         18: a = 32'h00000A30;  19: a = 32'h00000518;  20: a = 32'h0000028C;
         21: a = 32'h00000146;  22: a = 32'h000000A3;  23: a = 32'h00000051;
         24: a = 32'h00000029;  25: a = 32'h00000014;  26: a = 32'h0000000A;
         27: a = 32'h00000005;  28: a = 32'h00000003;  29: a = 32'h00000001;
         30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ----- rtl/spp_angle_conv.sv -----
// Three-stage conversion of a radian or degree angle to a 32-bit binary phase.
module spp_angle_conv import spp_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic                  degrees,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic [PHASE_BITS-1:0] phase
);

   localparam int RAD_W  = ANGLE_BITS + 31;
   localparam int DEG_S  = ANGLE_BITS + 6;
   localparam int DEG_W  = 2 * ANGLE_BITS + 1;
   localparam int DEG_T  = 38 - ANGLE_BITS;
   localparam logic [30:0] INV_PI = 31'h517CC1B7;
   localparam logic [ANGLE_BITS:0] RECIP45 = (ANGLE_BITS+1)'((64'd1 << DEG_S) / 64'd45);
   localparam logic [RAD_W-1:0] RAD_HALF = RAD_W'(64'd1 << (ANGLE_BITS - 3));

   typedef logic [PHASE_BITS-1:0] rest_tab_type [64];

   // Phase contributed by a remainder below 45, rounding folded in.
   function automatic rest_tab_type build_rest();
      rest_tab_type t;
      for (int r = 0; r < 64; r++) begin
         t[r] = (r < 45) ? PHASE_BITS'(((64'(r) << DEG_T) + 64'd22) / 64'd45) : '0;
      end
      return t;
   endfunction

   localparam rest_tab_type REST = build_rest();

   logic [RAD_W-1:0]      rad_prod_ff, rad_prod_in;
   logic [DEG_W-1:0]      deg_prod_ff, deg_prod_in;
   logic [ANGLE_BITS-1:0] angle_ff;
   logic [PHASE_BITS-1:0] rad_phase_ff, rad_phase_in;
   logic [ANGLE_BITS-1:0] quo_ff, quo_in;
   logic [5:0]            rem_ff, rem_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [RAD_W-1:0]      rad_round;
   logic [ANGLE_BITS-1:0] quo_est;
   logic [ANGLE_BITS:0]   rem_est;
   logic [PHASE_BITS-1:0] deg_phase;

   always_comb begin
      rad_prod_in  = RAD_W'(angle) * RAD_W'(INV_PI);
      deg_prod_in  = DEG_W'(angle) * DEG_W'(RECIP45);
      rad_round    = rad_prod_ff + RAD_HALF;
      rad_phase_in = PHASE_BITS'(rad_round >> (ANGLE_BITS - 2));
      quo_est      = ANGLE_BITS'(deg_prod_ff >> DEG_S);
      rem_est      = (ANGLE_BITS+1)'(angle_ff) - (ANGLE_BITS+1)'(quo_est) * (ANGLE_BITS+1)'(45);
      if (rem_est >= (ANGLE_BITS+1)'(45)) begin
         quo_in = quo_est + ANGLE_BITS'(1);
         rem_in = 6'(rem_est - (ANGLE_BITS+1)'(45));
      end else begin
         quo_in = quo_est;
         rem_in = 6'(rem_est);
      end
      deg_phase = (PHASE_BITS'(quo_ff) << DEG_T) + REST[rem_ff];
      phase_in  = degrees ? deg_phase : rad_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_prod_ff  <= rad_prod_in;
         deg_prod_ff  <= deg_prod_in;
         angle_ff     <= angle;
         rad_phase_ff <= rad_phase_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         phase_ff     <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

// ----- rtl/spp_cordic_cell.sv -----
// One rotation step of the CORDIC chain.
module spp_cordic_cell import spp_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [TRIG_W-1:0] in_x,
   input  logic signed [TRIG_W-1:0] in_y,
   input  logic signed [TRIG_W-1:0] in_z,
   input  logic                     in_flip,
   output logic signed [TRIG_W-1:0] out_x,
   output logic signed [TRIG_W-1:0] out_y,
   output logic signed [TRIG_W-1:0] out_z,
   output logic                     out_flip
);

   localparam logic signed [TRIG_W-1:0] ARC = TRIG_W'(arc_angle(IDX % 32));

   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, dx, dy;
   logic flip_ff;

   always_comb begin
      dx = in_y >>> (IDX % 32);
      dy = in_x >>> (IDX % 32);
      if (!in_z[TRIG_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ARC;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ARC;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         flip_ff <= in_flip;
      end
   end

   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_flip = flip_ff;

endmodule

// ----- rtl/spp_cordic.sv -----
// Pipelined CORDIC: phase fold, a chain of rotation cells and the output sign fix.
module spp_cordic import spp_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [PHASE_BITS-1:0]    phase,
   output logic signed [TRIG_W-1:0] sin_out,
   output logic signed [TRIG_W-1:0] cos_out
);

   localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(64'h40000000);
   localparam logic [PHASE_BITS-1:0] HALF    = PHASE_BITS'(64'h80000000);

   logic signed [TRIG_W-1:0] cx [STAGES+1];
   logic signed [TRIG_W-1:0] cy [STAGES+1];
   logic signed [TRIG_W-1:0] cz [STAGES+1];
   logic                     cf [STAGES+1];
   logic [PHASE_BITS-1:0]    quarter_sum, folded;
   logic signed [TRIG_W-1:0] sin_ff, sin_in, cos_ff, cos_in;

   // Fold into [-pi/2, pi/2) by a half-turn step; the results are negated later.
   always_comb begin
      quarter_sum = phase + QUARTER;
      folded      = quarter_sum[PHASE_BITS-1] ? (phase ^ HALF) : phase;
   end

   assign cx[0] = CORDIC_START;
   assign cy[0] = '0;
   assign cz[0] = TRIG_W'($signed(folded));
   assign cf[0] = quarter_sum[PHASE_BITS-1];

   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      spp_cordic_cell #(.IDX(g)) u_cell (
         .clock(clock), .en(en),
         .in_x(cx[g]), .in_y(cy[g]), .in_z(cz[g]), .in_flip(cf[g]),
         .out_x(cx[g+1]), .out_y(cy[g+1]), .out_z(cz[g+1]), .out_flip(cf[g+1])
      );
   end

   always_comb begin
      sin_in = cf[STAGES] ? -cy[STAGES] : cy[STAGES];
      cos_in = cf[STAGES] ? -cx[STAGES] : cx[STAGES];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ----- rtl/spherical_point_proximity.sv -----
// Top level of the spherical point proximity check.
// A request passes through the angle conversion stages, a register in each CORDIC cell
// and the sign fix register, two product stages, and difference, square and compare
// stages before its response is valid.
// Throughput is one transaction per cycle; the whole pipeline moves while the response
// register is empty or being taken. Reset clears the valid bits and loads the register defaults.
module spherical_point_proximity import spp_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [POS_BITS-1:0]     csr_data
);

   // Pipeline depth in front of the first product stage.
   localparam int FRONT   = 3 + STAGES + 1;
   localparam int MAG_W   = TRIG_W - 1;
   localparam int MAG1_W  = POS_BITS + MAG_W - TRIG_FRAC;
   localparam int MAG2_W  = MAG1_W + MAG_W - TRIG_FRAC;
   localparam int COORD_W = MAG2_W + 1;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int TSQ_W   = 2 * POS_BITS;
   localparam logic [POS_BITS+MAG_W-1:0] RND1 = (POS_BITS+MAG_W)'(64'd1 << (TRIG_FRAC-1));
   localparam logic [MAG1_W+MAG_W-1:0]   RND2 = (MAG1_W+MAG_W)'(64'd1 << (TRIG_FRAC-1));

   // Configuration registers; writes are always taken.
   logic [POS_BITS-1:0] tol_ff;
   logic                deg_ff;
   logic [TSQ_W-1:0]    tol_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= POS_BITS'(256);
         deg_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOLERANCE:  tol_ff <= csr_data;
            CSR_ANGLE_UNIT: deg_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The squared tolerance follows the register; it is settled long before any
   // transaction reaches the compare stage.
   always_ff @(posedge clock) begin
      tol_sq_ff <= TSQ_W'(tol_ff) * TSQ_W'(tol_ff);
   end

   // The pipeline advances as a whole unless a finished response is held.
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // Angle conversion and CORDIC for both angles of both points.
   logic [PHASE_BITS-1:0]    ph [4];
   logic signed [TRIG_W-1:0] sn [4];
   logic signed [TRIG_W-1:0] cs [4];
   logic [ANGLE_BITS-1:0]    ang [4];

   assign ang[0] = req_data.incl_a;
   assign ang[1] = req_data.azim_a;
   assign ang[2] = req_data.incl_b;
   assign ang[3] = req_data.azim_b;

   for (genvar g = 0; g < 4; g++) begin : g_trig
      spp_angle_conv u_conv (
         .clock(clock), .en(en), .degrees(deg_ff), .angle(ang[g]), .phase(ph[g])
      );
      spp_cordic #(.STAGES(STAGES)) u_cordic (
         .clock(clock), .en(en), .phase(ph[g]), .sin_out(sn[g]), .cos_out(cs[g])
      );
   end

   // Side data travels alongside the trig pipeline.
   logic                valid_pipe_ff  [FRONT];
   logic                before_pipe_ff [FRONT];
   logic [POS_BITS-1:0] ra_pipe_ff     [FRONT];
   logic [POS_BITS-1:0] rb_pipe_ff     [FRONT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRONT; i++) valid_pipe_ff[i] <= 1'b0;
      end else if (en) begin
         valid_pipe_ff[0] <= req_valid;
         for (int i = 1; i < FRONT; i++) valid_pipe_ff[i] <= valid_pipe_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         before_pipe_ff[0] <= req_data.position_a < req_data.position_b;
         ra_pipe_ff[0]     <= req_data.position_a;
         rb_pipe_ff[0]     <= req_data.position_b;
         for (int i = 1; i < FRONT; i++) begin
            before_pipe_ff[i] <= before_pipe_ff[i-1];
            ra_pipe_ff[i]     <= ra_pipe_ff[i-1];
            rb_pipe_ff[i]     <= rb_pipe_ff[i-1];
         end
      end
   end

   // Magnitude of a trig value.
   function automatic logic [MAG_W-1:0] trig_mag(input logic signed [TRIG_W-1:0] v);
      logic [TRIG_W-1:0] a;
      a = v[TRIG_W-1] ? TRIG_W'(-v) : TRIG_W'(v);
      return a[MAG_W-1:0];
   endfunction

   // First products, r*sin(i) and r*cos(i), rounded on magnitude. Index 0 is point a.
   logic [MAG1_W-1:0] rs_mag_ff [2], rs_mag_in [2], rc_mag_ff [2], rc_mag_in [2];
   logic              rs_neg_ff [2], rc_neg_ff [2];
   logic [MAG_W-1:0]  sa_mag_ff [2], ca_mag_ff [2];
   logic              sa_neg_ff [2], ca_neg_ff [2];
   logic              m1_valid_ff, m1_before_ff;
   logic [POS_BITS+MAG_W-1:0] p1s [2], p1c [2];
   logic [POS_BITS-1:0] rad [2];

   assign rad[0] = ra_pipe_ff[FRONT-1];
   assign rad[1] = rb_pipe_ff[FRONT-1];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         p1s[k] = (POS_BITS+MAG_W)'(rad[k]) * (POS_BITS+MAG_W)'(trig_mag(sn[2*k]));
         p1c[k] = (POS_BITS+MAG_W)'(rad[k]) * (POS_BITS+MAG_W)'(trig_mag(cs[2*k]));
         rs_mag_in[k] = MAG1_W'((p1s[k] + RND1) >> TRIG_FRAC);
         rc_mag_in[k] = MAG1_W'((p1c[k] + RND1) >> TRIG_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            rs_mag_ff[k] <= rs_mag_in[k];
            rc_mag_ff[k] <= rc_mag_in[k];
            rs_neg_ff[k] <= sn[2*k][TRIG_W-1];
            rc_neg_ff[k] <= cs[2*k][TRIG_W-1];
            sa_mag_ff[k] <= trig_mag(sn[2*k+1]);
            ca_mag_ff[k] <= trig_mag(cs[2*k+1]);
            sa_neg_ff[k] <= sn[2*k+1][TRIG_W-1];
            ca_neg_ff[k] <= cs[2*k+1][TRIG_W-1];
         end
         m1_before_ff <= before_pipe_ff[FRONT-1];
      end
   end

   // Second products give x and y; z passes along. Coordinates are signed.
   logic signed [COORD_W-1:0] cx_ff [2], cy_ff [2], cz_ff [2];
   logic signed [COORD_W-1:0] cx_in [2], cy_in [2], cz_in [2];
   logic [MAG1_W+MAG_W-1:0] p2x [2], p2y [2];
   logic [MAG2_W-1:0] mx [2], my [2];
   logic m2_valid_ff, m2_before_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         p2x[k] = (MAG1_W+MAG_W)'(rs_mag_ff[k]) * (MAG1_W+MAG_W)'(ca_mag_ff[k]);
         p2y[k] = (MAG1_W+MAG_W)'(rs_mag_ff[k]) * (MAG1_W+MAG_W)'(sa_mag_ff[k]);
         mx[k]  = MAG2_W'((p2x[k] + RND2) >> TRIG_FRAC);
         my[k]  = MAG2_W'((p2y[k] + RND2) >> TRIG_FRAC);
         cx_in[k] = (rs_neg_ff[k] ^ ca_neg_ff[k]) ? -$signed({1'b0, mx[k]})
                                                  : $signed({1'b0, mx[k]});
         cy_in[k] = (rs_neg_ff[k] ^ sa_neg_ff[k]) ? -$signed({1'b0, my[k]})
                                                  : $signed({1'b0, my[k]});
         cz_in[k] = rc_neg_ff[k] ? -$signed(COORD_W'(rc_mag_ff[k]))
                                 : $signed(COORD_W'(rc_mag_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            cx_ff[k] <= cx_in[k];
            cy_ff[k] <= cy_in[k];
            cz_ff[k] <= cz_in[k];
         end
         m2_before_ff <= m1_before_ff;
      end
   end

   // Absolute coordinate differences.
   logic [DIFF_W-1:0] d_ff [3], d_in [3];
   logic signed [DIFF_W-1:0] dd [3];
   logic s1_valid_ff, s1_before_ff;

   always_comb begin
      dd[0] = DIFF_W'(cx_ff[0]) - DIFF_W'(cx_ff[1]);
      dd[1] = DIFF_W'(cy_ff[0]) - DIFF_W'(cy_ff[1]);
      dd[2] = DIFF_W'(cz_ff[0]) - DIFF_W'(cz_ff[1]);
      for (int j = 0; j < 3; j++) d_in[j] = dd[j][DIFF_W-1] ? DIFF_W'(-dd[j]) : DIFF_W'(dd[j]);
   end

   // Squares, then the sum and the strict compare against the squared tolerance.
   logic [SQ_W-1:0] sq_ff [3];
   logic s2_valid_ff, s2_before_ff;
   logic [SUM_W-1:0] dist_sq;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;

   always_comb begin
      dist_sq = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      rsp_in.is_close   = dist_sq < SUM_W'(tol_sq_ff);
      rsp_in.a_before_b = s2_before_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            d_ff[j]  <= d_in[j];
            sq_ff[j] <= SQ_W'(d_ff[j]) * SQ_W'(d_ff[j]);
         end
         s1_before_ff <= m2_before_ff;
         s2_before_ff <= s1_before_ff;
         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff  <= valid_pipe_ff[FRONT-1];
         m2_valid_ff  <= m1_valid_ff;
         s1_valid_ff  <= m2_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
